@@ rtl/gbr_pkg.sv @@
package gbr_pkg;

  // Pin count of the two banks together (bank 1 holds NUM_PINS - 32 pins).
  localparam int unsigned NumPinsDefault = 64;

  // Index width of a pin configuration word (up to 64 pins).
  localparam int unsigned CfgIdxW = 6;

  // Width of a pin configuration word.
  localparam int unsigned CfgWordW = 14;

  // Lock keys.
  localparam logic [31:0] UnlockKey = 32'h0000_DF0D;
  localparam logic [31:0] LockKey   = 32'h0000_767B;

  // GPIO space offsets.
  localparam logic [11:0] GpioDataEnd   = 12'h010;
  localparam logic [11:0] GpioLevels0   = 12'h060;
  localparam logic [11:0] GpioLevels1   = 12'h064;
  localparam logic [11:0] GpioDir0      = 12'h204;
  localparam logic [11:0] GpioOe0       = 12'h208;
  localparam logic [11:0] GpioDir1      = 12'h244;
  localparam logic [11:0] GpioOe1       = 12'h248;

  // System-control space offsets.
  localparam logic [11:0] SysLockKey    = 12'h004;
  localparam logic [11:0] SysUnlockKey  = 12'h008;
  localparam logic [11:0] SysLockStatus = 12'h00C;
  localparam logic [11:0] SysCfgBase    = 12'h700;

  // Register selected by one access.
  typedef enum logic [3:0] {
    DEC_UNMAPPED,
    DEC_DATA,
    DEC_LEVELS,
    DEC_DIR,
    DEC_OE,
    DEC_LOCK_KEY,
    DEC_UNLOCK_KEY,
    DEC_LOCK_STATUS,
    DEC_CFG
  } gbr_kind_e;

  // Address decode result handed from the decoder to the register bank.
  typedef struct packed {
    gbr_kind_e            kind;
    logic                 bank;
    logic                 half;
    logic [CfgIdxW-1:0]   cfg_idx;
  } gbr_dec_t;

endpackage

@@ rtl/gbr_ram.sv @@
module gbr_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gbr_decode.sv @@
module gbr_decode #(
  parameter int unsigned NUM_PINS = gbr_pkg::NumPinsDefault
) (
  input  logic              region_i,
  input  logic [11:0]       offset_i,
  output gbr_pkg::gbr_dec_t dec_o
);

  import gbr_pkg::*;

  logic [11:0] cfg_diff;
  logic [9:0]  cfg_n;
  logic        aligned;

  assign cfg_diff = offset_i - SysCfgBase;
  assign cfg_n    = cfg_diff[11:2];
  assign aligned  = (offset_i[1:0] == 2'b00);

  // Map the region and offset of one item onto a register.
  always_comb begin
    dec_o.kind    = DEC_UNMAPPED;
    dec_o.bank    = 1'b0;
    dec_o.half    = 1'b0;
    dec_o.cfg_idx = offset_i[7:2];
    if (!region_i) begin
      if (offset_i < GpioDataEnd && aligned) begin
        dec_o.kind = DEC_DATA;
        dec_o.bank = offset_i[3];
        dec_o.half = offset_i[2];
      end else begin
        case (offset_i)
          GpioLevels0: dec_o.kind = DEC_LEVELS;
          GpioLevels1: begin
            dec_o.kind = DEC_LEVELS;
            dec_o.bank = 1'b1;
          end
          GpioDir0: dec_o.kind = DEC_DIR;
          GpioDir1: begin
            dec_o.kind = DEC_DIR;
            dec_o.bank = 1'b1;
          end
          GpioOe0: dec_o.kind = DEC_OE;
          GpioOe1: begin
            dec_o.kind = DEC_OE;
            dec_o.bank = 1'b1;
          end
          default: dec_o.kind = DEC_UNMAPPED;
        endcase
      end
    end else begin
      case (offset_i)
        SysLockKey:    dec_o.kind = DEC_LOCK_KEY;
        SysUnlockKey:  dec_o.kind = DEC_UNLOCK_KEY;
        SysLockStatus: dec_o.kind = DEC_LOCK_STATUS;
        default: begin
          if (offset_i >= SysCfgBase && aligned && 32'(cfg_n) < NUM_PINS) begin
            dec_o.kind = DEC_CFG;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/gpio_bank_register_block_core.sv @@
// An accepted item passes through the input register and then the result register,
// whose outputs show its result with done_o high.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// The configuration words sit in a registered-read RAM with write forwarding.
// Reset (rst_ni low, asynchronous) clears all pin registers and closes the lock;
// per-word valid flags make every configuration word read as zero until written.
module gpio_bank_register_block_core #(
  parameter int unsigned NUM_PINS = gbr_pkg::NumPinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        action_i,
  input  logic        region_i,
  input  logic [11:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic [63:0] pin_levels_i,
  output logic [31:0] read_data_o,
  output logic        access_error_o,
  output logic [63:0] pin_drive_o,
  output logic [63:0] pin_drive_enable_o
);

  import gbr_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_PINS);
  localparam logic [31:0] Bank1Mask = 32'((64'd1 << (NUM_PINS - 32)) - 64'd1);

  // Input register.
  logic        vld_q;
  logic        action_q;
  logic        region_q;
  logic [11:0] offset_q;
  logic [31:0] wdata_q;
  logic [63:0] levels_q;

  // Register bank state.
  logic [31:0] od_q  [2];
  logic [31:0] od_d  [2];
  logic [31:0] dir_q [2];
  logic [31:0] dir_d [2];
  logic [31:0] oe_q  [2];
  logic [31:0] oe_d  [2];
  logic        locked_q, locked_d;
  logic [NUM_PINS-1:0] cfg_vld_q;

  // Result register.
  logic        done_q;
  logic [31:0] rdata_q, rdata_d;
  logic        err_q, err_d;

  // Configuration word RAM and its forwarding path.
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [IdxW-1:0]     ram_raddr;
  logic [CfgWordW-1:0] ram_rdata;
  logic                fwd_q, fwd_d;
  logic [CfgWordW-1:0] fwd_data_q;
  logic [CfgWordW-1:0] cfg_word;

  gbr_dec_t    dec;
  logic [31:0] bank_mask;
  logic [31:0] od_sel;
  logic [15:0] chg;

  assign busy = 1'b0;

  // Capture each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_i;
    region_q <= region_i;
    offset_q <= offset_i;
    wdata_q  <= write_data_i;
    levels_q <= pin_levels_i;
  end

  gbr_decode #(
    .NUM_PINS(NUM_PINS)
  ) u_decode (
    .region_i(region_q),
    .offset_i(offset_q),
    .dec_o   (dec)
  );

  // The read address comes straight from the ports, so the word is ready
  // when the item reaches the input register.
  assign ram_raddr = offset_i[IdxW+1:2];
  assign ram_waddr = dec.cfg_idx[IdxW-1:0];

  gbr_ram #(
    .WIDTH(CfgWordW),
    .DEPTH(NUM_PINS)
  ) u_cfg_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wdata_q[CfgWordW-1:0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A write in the same cycle as the read of that word wins over the RAM data.
  assign fwd_d = ram_we && (ram_waddr == ram_raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata_q[CfgWordW-1:0];
  end

  always_comb begin
    if (!cfg_vld_q[ram_waddr]) begin
      cfg_word = '0;
    end else if (fwd_q) begin
      cfg_word = fwd_data_q;
    end else begin
      cfg_word = ram_rdata;
    end
  end

  assign bank_mask = dec.bank ? Bank1Mask : 32'hFFFF_FFFF;
  assign od_sel    = dec.bank ? od_q[1] : od_q[0];
  assign chg       = ~wdata_q[31:16];

  // Carry out the access held in the input register.
  always_comb begin
    od_d     = od_q;
    dir_d    = dir_q;
    oe_d     = oe_q;
    locked_d = locked_q;
    rdata_d  = '0;
    err_d    = 1'b0;
    ram_we   = 1'b0;
    if (vld_q) begin
      case (dec.kind)
        DEC_DATA: begin
          if (action_q) begin
            if (dec.half) begin
              od_d[dec.bank] = {(od_sel[31:16] & ~chg) | (chg & wdata_q[15:0]),
                                od_sel[15:0]} & bank_mask;
            end else begin
              od_d[dec.bank] = {od_sel[31:16],
                                (od_sel[15:0] & ~chg) | (chg & wdata_q[15:0])} & bank_mask;
            end
          end else begin
            rdata_d = {16'h0000, dec.half ? od_sel[31:16] : od_sel[15:0]};
          end
        end
        DEC_LEVELS: begin
          rdata_d = dec.bank ? (levels_q[63:32] & Bank1Mask) : levels_q[31:0];
        end
        DEC_DIR: begin
          if (action_q) begin
            dir_d[dec.bank] = wdata_q & bank_mask;
          end else begin
            rdata_d = dec.bank ? dir_q[1] : dir_q[0];
          end
        end
        DEC_OE: begin
          if (action_q) begin
            oe_d[dec.bank] = wdata_q & bank_mask;
          end else begin
            rdata_d = dec.bank ? oe_q[1] : oe_q[0];
          end
        end
        DEC_LOCK_KEY: begin
          if (action_q && wdata_q == LockKey) begin
            locked_d = 1'b1;
          end
        end
        DEC_UNLOCK_KEY: begin
          if (action_q && wdata_q == UnlockKey) begin
            locked_d = 1'b0;
          end
        end
        DEC_LOCK_STATUS: begin
          rdata_d = {31'd0, locked_q};
        end
        DEC_CFG: begin
          if (action_q) begin
            if (locked_q) begin
              err_d = 1'b1;
            end else begin
              ram_we = 1'b1;
            end
          end else begin
            rdata_d = {{(32 - CfgWordW){1'b0}}, cfg_word};
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
      if (action_q || err_d) begin
        rdata_d = '0;
      end
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      od_q      <= '{default: '0};
      dir_q     <= '{default: '0};
      oe_q      <= '{default: '0};
      locked_q  <= 1'b1;
      cfg_vld_q <= '0;
      done_q    <= 1'b0;
    end else begin
      od_q     <= od_d;
      dir_q    <= dir_d;
      oe_q     <= oe_d;
      locked_q <= locked_d;
      if (ram_we) begin
        cfg_vld_q[ram_waddr] <= 1'b1;
      end
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    err_q   <= err_d;
  end

  // Pin outputs follow the bank state; bank 1 never stores unused bits.
  assign done_o             = done_q;
  assign read_data_o        = rdata_q;
  assign access_error_o     = err_q;
  assign pin_drive_o        = {od_q[1], od_q[0]};
  assign pin_drive_enable_o = {dir_q[1] & oe_q[1], dir_q[0] & oe_q[0]};

endmodule

@@ rtl/gbr_checker.sv @@
module gbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        action_i,
  input logic        region_i,
  input logic [11:0] offset_i,
  input logic [31:0] write_data_i,
  input logic [63:0] pin_levels_i,
  input logic [31:0] read_data_o,
  input logic        access_error_o,
  input logic [63:0] pin_drive_o,
  input logic [63:0] pin_drive_enable_o
);

  // Every accepted item yields its result through the input and result registers.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing two cycles after an accepted item");

  // No result appears without an accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##2 !done_o)
    else $error("result without an accepted item");

  // Writes and failed accesses return zero data.
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (access_error_o || $past(action_i, 2))) |-> (read_data_o == 32'd0))
    else $error("nonzero read data on a write or an error");

  // Pin outputs change only together with a result.
  a_drive_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> ($stable(pin_drive_o) && $stable(pin_drive_enable_o)))
    else $error("pin outputs changed without an item");

endmodule

bind gpio_bank_register_block_core gbr_checker u_gbr_checker (.*);
